FILE: rtl/core/glyph_cell_rasterizer_assert.svh
// Assertion macros of the glyph cell rasterizer checker
`ifndef GLYPH_CELL_RASTERIZER_ASSERT_SVH
`define GLYPH_CELL_RASTERIZER_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low
`define GCR_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("glyph_cell_rasterizer: assertion failed");

// Next-cycle implication, sampled on clk, quiet while rst_n is low
`define GCR_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("glyph_cell_rasterizer: assertion failed");

`endif

FILE: rtl/core/gcr_pkg.sv
// Package: types, constants and codes of the glyph cell rasterizer
package gcr_pkg;

    // Font geometry
    localparam int GLYPH_COUNT_DEF = 256;
    localparam int GLYPH_COLUMNS   = 5;
    localparam int GLYPH_ROWS      = 8;
    localparam logic [7:0] REMAP_START = 8'd176;

    // Window limits and reset values
    localparam logic [10:0] WIN_MAX        = 11'd1024;
    localparam logic [10:0] WIN_WIDTH_RST  = 11'd320;
    localparam logic [10:0] WIN_HEIGHT_RST = 11'd240;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 1'b1;

    // Command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DRAW = 1'b1;

    // Internal coordinate width (signed, no wrap)
    localparam int COORD_W = 18;

    // Column/row counter width (columns 0..5 including background)
    localparam int CNT_W = 3;

    typedef struct packed {
        logic               cmd;
        logic [10:0]        font_index;
        logic [7:0]         font_byte;
        logic [7:0]         char_code;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [15:0]        fg_color;
        logic [15:0]        bg_color;
        logic [7:0]         glyph_scale;
    } gcr_in_t;

    typedef struct packed {
        logic [9:0]  rect_x;
        logic [9:0]  rect_y;
        logic [10:0] rect_w;
        logic [10:0] rect_h;
        logic [15:0] fill_color;
        logic        write_enable;
        logic        last;
    } gcr_out_t;

    // Controller to datapath
    typedef struct packed {
        logic             accept;
        logic             fetch;
        logic             emit;
        logic             tall;
        logic             last;
        logic             col_adv;
        logic [CNT_W-1:0] col;
        logic [CNT_W-1:0] row;
    } gcr_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic in_draw;
        logic opaque;
        logic scale_one;
    } gcr_stat_t;

endpackage

FILE: rtl/core/gcr_ctrl.sv
// Controller: sequences fetch and cell emission for one draw request
module gcr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  gcr_pkg::gcr_stat_t stat,
    output gcr_pkg::gcr_cmd_t  cmd
);
    import gcr_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_CELL  = 2'd2;
    localparam logic [1:0] S_TALL  = 2'd3;

    localparam logic [CNT_W-1:0] ROW_LAST = CNT_W'(GLYPH_ROWS - 1);
    localparam logic [CNT_W-1:0] COL_LAST = CNT_W'(GLYPH_COLUMNS - 1);
    localparam logic [CNT_W-1:0] COL_BG   = CNT_W'(GLYPH_COLUMNS);

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] row_reg, row_next;
    logic             out_valid_reg, out_valid_next;
    logic             emit_ok;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign emit_ok   = !out_valid_reg || out_ready;

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        cmd         = '0;
        cmd.accept  = in_valid && in_ready;
        cmd.col     = col_reg;
        cmd.row     = row_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.accept && stat.in_draw)
                begin
                    col_next   = '0;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                row_next   = '0;
                state_next = S_CELL;
            end
            S_CELL:
            begin
                if (emit_ok)
                begin
                    cmd.emit = 1'b1;
                    row_next = row_reg + 1'b1;
                    if (row_reg == ROW_LAST)
                    begin
                        cmd.col_adv = 1'b1;
                        if (col_reg == COL_LAST)
                        begin
                            if (stat.opaque && stat.scale_one)
                            begin
                                col_next   = COL_BG;
                                state_next = S_FETCH;
                            end
                            else if (stat.opaque)
                            begin
                                state_next = S_TALL;
                            end
                            else
                            begin
                                cmd.last   = 1'b1;
                                state_next = S_IDLE;
                            end
                        end
                        else if (col_reg == COL_BG)
                        begin
                            cmd.last   = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            col_next   = col_reg + 1'b1;
                            state_next = S_FETCH;
                        end
                    end
                end
            end
            S_TALL:
            begin
                if (emit_ok)
                begin
                    cmd.emit   = 1'b1;
                    cmd.tall   = 1'b1;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid flag
    always_comb
    begin
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: rtl/core/gcr_datapath.sv
// Datapath: font store, window registers, cell coordinates, clipping, output register
module gcr_datapath #(
    parameter int GLYPH_COUNT = gcr_pkg::GLYPH_COUNT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [gcr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gcr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  gcr_pkg::gcr_in_t                in_data,
    input  gcr_pkg::gcr_cmd_t               cmd,
    output gcr_pkg::gcr_stat_t              stat,
    output gcr_pkg::gcr_out_t               out_data
);
    import gcr_pkg::*;

    localparam int DEPTH = GLYPH_COUNT * GLYPH_COLUMNS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CNT_W-1:0] COL_BG = CNT_W'(GLYPH_COLUMNS);

    // Font store (no reset)
    logic [7:0] font_mem [DEPTH];
    logic [7:0] rd_data_reg;

    // Window limits, stored already clamped to 1024
    logic [10:0] win_w_reg, win_h_reg;

    // Per-draw registers
    logic [10:0]              base_reg;
    logic                     oob_reg;
    logic                     opaque_reg;
    logic [7:0]               scale_reg;
    logic [15:0]              fg_reg, bg_reg;
    logic signed [COORD_W-1:0] pos_y_reg;
    logic signed [COORD_W-1:0] cur_x_reg, cur_x_end_reg;
    logic signed [COORD_W-1:0] cur_y_reg, cur_y_end_reg;
    gcr_out_t                 out_reg;

    logic                     in_draw;
    logic [7:0]               code_rm;
    logic [10:0]              base_next;
    logic [10:0]              rd_addr;
    logic signed [COORD_W-1:0] px_ext, py_ext, s_ext;
    logic [7:0]               line;
    logic                     dot;
    logic signed [COORD_W-1:0] x0, x1, y0, y1;
    logic signed [COORD_W-1:0] ww_s, wh_s;
    logic signed [COORD_W-1:0] left, right, top, bottom;
    logic signed [COORD_W-1:0] w_diff, h_diff;
    logic                     empty;

    // Decode of the request at the input
    assign in_draw  = (in_data.cmd == CMD_DRAW) && (in_data.glyph_scale != 8'd0);
    assign code_rm  = (in_data.char_code >= REMAP_START) ? in_data.char_code + 8'd1
                                                         : in_data.char_code;
    assign base_next = {1'b0, code_rm, 2'b00} + {3'b000, code_rm};
    assign px_ext    = {{(COORD_W-16){in_data.pos_x[15]}}, in_data.pos_x};
    assign py_ext    = {{(COORD_W-16){in_data.pos_y[15]}}, in_data.pos_y};
    assign s_ext     = {{(COORD_W-8){1'b0}}, scale_reg};

    assign stat.in_draw   = in_draw;
    assign stat.opaque    = opaque_reg;
    assign stat.scale_one = (scale_reg == 8'd1);

    // Window registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_w_reg <= WIN_WIDTH_RST;
            win_h_reg <= WIN_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_WINDOW_WIDTH)
                win_w_reg <= (cfg_data > WIN_MAX) ? WIN_MAX : cfg_data;
            else if (cfg_index == REG_WINDOW_HEIGHT)
                win_h_reg <= (cfg_data > WIN_MAX) ? WIN_MAX : cfg_data;
        end
    end

    // Font store: load writes, column fetch reads
    assign rd_addr = base_reg + {{(11-CNT_W){1'b0}}, cmd.col};

    always_ff @(posedge clk)
    begin
        if (cmd.accept && (in_data.cmd == CMD_LOAD) && (in_data.font_index < 11'(DEPTH)))
            font_mem[in_data.font_index[AW-1:0]] <= in_data.font_byte;
        if (cmd.fetch)
            rd_data_reg <= font_mem[rd_addr[AW-1:0]];
    end

    // Draw parameters latched at accept
    always_ff @(posedge clk)
    begin
        if (cmd.accept && in_draw)
        begin
            base_reg   <= base_next;
            oob_reg    <= ({1'b0, code_rm} >= 9'(GLYPH_COUNT));
            opaque_reg <= (in_data.bg_color != in_data.fg_color);
            scale_reg  <= in_data.glyph_scale;
            fg_reg     <= in_data.fg_color;
            bg_reg     <= in_data.bg_color;
            pos_y_reg  <= py_ext;
        end
    end

    // Running cell edges, stepped by the scale
    always_ff @(posedge clk)
    begin
        if (cmd.accept && in_draw)
        begin
            cur_x_reg     <= px_ext;
            cur_x_end_reg <= px_ext + {{(COORD_W-8){1'b0}}, in_data.glyph_scale};
        end
        else if (cmd.emit && !cmd.tall && cmd.col_adv)
        begin
            cur_x_reg     <= cur_x_reg + s_ext;
            cur_x_end_reg <= cur_x_end_reg + s_ext;
        end

        if (cmd.fetch)
        begin
            cur_y_reg     <= pos_y_reg;
            cur_y_end_reg <= pos_y_reg + s_ext;
        end
        else if (cmd.emit && !cmd.tall)
        begin
            cur_y_reg     <= cur_y_reg + s_ext;
            cur_y_end_reg <= cur_y_end_reg + s_ext;
        end
    end

    // Dot of the current cell; background column and unknown glyphs read blank
    assign line = ((cmd.col == COL_BG) || oob_reg) ? 8'd0 : rd_data_reg;
    assign dot  = line[cmd.row];

    // Cell edges; the tall background rectangle spans the whole glyph height
    assign x0 = cur_x_reg;
    assign x1 = cur_x_end_reg;
    assign y0 = cmd.tall ? pos_y_reg : cur_y_reg;
    assign y1 = cmd.tall ? cur_y_reg : cur_y_end_reg;

    // Clip to the window
    assign ww_s   = {{(COORD_W-11){1'b0}}, win_w_reg};
    assign wh_s   = {{(COORD_W-11){1'b0}}, win_h_reg};
    assign left   = (x0 > 0) ? x0 : '0;
    assign top    = (y0 > 0) ? y0 : '0;
    assign right  = (x1 > ww_s) ? ww_s : x1;
    assign bottom = (y1 > wh_s) ? wh_s : y1;
    assign empty  = (right <= left) || (bottom <= top);
    assign w_diff = right - left;
    assign h_diff = bottom - top;

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_reg.rect_x       <= empty ? 10'd0 : left[9:0];
            out_reg.rect_y       <= empty ? 10'd0 : top[9:0];
            out_reg.rect_w       <= empty ? 11'd0 : w_diff[10:0];
            out_reg.rect_h       <= empty ? 11'd0 : h_diff[10:0];
            out_reg.fill_color   <= (cmd.tall || !dot) ? bg_reg : fg_reg;
            out_reg.write_enable <= !empty && (cmd.tall || dot || opaque_reg);
            out_reg.last         <= cmd.last;
        end
    end

    assign out_data = out_reg;

endmodule

FILE: rtl/core/glyph_cell_rasterizer.sv
// Top level of the glyph cell rasterizer: controller plus datapath
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------
//  cfg      | in        | cfg_we             | cfg_index, cfg_data (window)
//  in       | in        | in_valid/in_ready  | in_data  (load or draw)
//  out      | out       | out_valid/out_ready| out_data (one cell rectangle)
//
// A load request gives no result; neither does a zero-scale draw. A draw is
// accepted, then each column takes one font store read and eight cells; an
// opaque glyph adds a background column, one tall cell or at scale one a read
// and eight one-pixel cells. Reset clears the controller and presets the window
// registers; the font store keeps its contents and is undefined until loaded.
// A low out_ready holds the next cell. The next request is taken while the
// final result still waits in the output.
module glyph_cell_rasterizer #(
    parameter int GLYPH_COUNT = gcr_pkg::GLYPH_COUNT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [gcr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gcr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  gcr_pkg::gcr_in_t                in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output gcr_pkg::gcr_out_t               out_data
);
    import gcr_pkg::*;

    gcr_cmd_t  cmd;
    gcr_stat_t stat;

    gcr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    gcr_datapath #(
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (out_data)
    );

endmodule

FILE: rtl/core/gcr_checker.sv
// Port-level checker for the glyph cell rasterizer, bound to the top level
`include "glyph_cell_rasterizer_assert.svh"

module gcr_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input gcr_pkg::gcr_in_t  in_data,
    input logic              out_valid,
    input logic              out_ready,
    input gcr_pkg::gcr_out_t out_data
);
    import gcr_pkg::*;

    logic draw_acc;

    // Accepted draw request that renders cells
    assign draw_acc = in_valid && in_ready && (in_data.cmd == CMD_DRAW) &&
                      (in_data.glyph_scale != 8'd0);

    // A stalled result holds
    `GCR_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

    // A load request into an empty output gives no result
    `GCR_ASSERT_NXT(a_load_silent, in_valid && in_ready && (in_data.cmd == CMD_LOAD) && !out_valid, !out_valid)

    // A zero-scale draw into an empty output gives no result
    `GCR_ASSERT_NXT(a_zero_scale_silent, in_valid && in_ready && (in_data.glyph_scale == 8'd0) && !out_valid, !out_valid)

    // A draw in progress holds off the next request
    `GCR_ASSERT_NXT(a_draw_busy, draw_acc, !in_ready)

    // An enabled rectangle is never empty
    `GCR_ASSERT_IMP(a_enable_nonempty, out_valid && out_data.write_enable, (out_data.rect_w != 11'd0) && (out_data.rect_h != 11'd0))

endmodule

bind glyph_cell_rasterizer gcr_checker u_gcr_checker (.*);

FILE: test/tb_top.sv
// Self-checking testbench of the glyph cell rasterizer: directed requests, then random requests
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gcr_pkg::*;

    localparam int STORE_DEPTH   = GLYPH_COUNT_DEF * GLYPH_COLUMNS;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 400;
    localparam int N_PHASES      = 8;

    typedef gcr_out_t cell_list_t[$];

    // One row of the directed table; typed rows carry a hand-written expectation
    typedef struct {
        gcr_in_t     req;
        bit          typed;
        int          n;
        gcr_out_t    typed_cell;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    gcr_in_t                in_data;
    logic                   out_valid;
    logic                   out_ready;
    gcr_out_t               out_data;

    logic                   rx_ready;
    logic                   rx_hold;
    bit                     no_idle;
    event                   hold_start;

    // Predictor state: font mirror and window registers
    logic [7:0]             font_mirror [STORE_DEPTH];
    bit                     font_loaded [STORE_DEPTH];
    logic [10:0]            win_w;
    logic [10:0]            win_h;

    gcr_out_t               pending_cells[$];
    stim_row_t              directed_rows[$];
    logic [7:0]             ready_codes[$];

    int                     phase_items;
    int                     loads_sent;
    int                     draws_sent;
    int                     cells_checked;
    int                     settings_written;
    int                     mismatches;

    assign out_ready = rx_ready && !rx_hold;

    glyph_cell_rasterizer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int idle_cycles();
        return no_idle ? 0 : $urandom_range(0, 5);
    endfunction

    // Codes from 176 up move up by one, wrapping at 8 bits
    function automatic logic [7:0] remap_code(input logic [7:0] code);
        return (code >= REMAP_START) ? code + 8'd1 : code;
    endfunction

    // Clip one rectangle to the window; a clipped-away rectangle has zero position and size, not written
    function automatic gcr_out_t clip_cell(input int px, input int py, input int w,
                                           input int h, input logic [15:0] color,
                                           input bit en);
        gcr_out_t c;
        int left;
        int top;
        int right;
        int bottom;
        int ww;
        int wh;
        ww = (win_w > WIN_MAX) ? int'(WIN_MAX) : int'(win_w);
        wh = (win_h > WIN_MAX) ? int'(WIN_MAX) : int'(win_h);
        left = (px > 0) ? px : 0;
        top = (py > 0) ? py : 0;
        right = px + w;
        bottom = py + h;
        if (right > ww)
            right = ww;
        if (bottom > wh)
            bottom = wh;
        c = '0;
        if (right <= left || bottom <= top)
        begin
            en = 1'b0;
        end
        else
        begin
            c.rect_x = 10'(left);
            c.rect_y = 10'(top);
            c.rect_w = 11'(right - left);
            c.rect_h = 11'(bottom - top);
        end
        c.fill_color = color;
        c.write_enable = en;
        c.last = 1'b0;
        return c;
    endfunction

    // Expected cells of one request; a load only updates the font mirror
    function automatic cell_list_t predict_request(input gcr_in_t req);
        cell_list_t cells;
        gcr_out_t tail;
        logic [7:0] glyph;
        logic [7:0] line;
        logic [15:0] color;
        int px;
        int py;
        int s;
        bit opaque;
        cells = {};
        if (req.cmd == CMD_LOAD)
        begin
            if (int'(req.font_index) < STORE_DEPTH)
            begin
                font_mirror[req.font_index] = req.font_byte;
                font_loaded[req.font_index] = 1'b1;
            end
            return cells;
        end
        s = int'(req.glyph_scale);
        if (s == 0)
            return cells;
        glyph = remap_code(req.char_code);
        px = int'($signed(req.pos_x));
        py = int'($signed(req.pos_y));
        opaque = (req.bg_color != req.fg_color);
        for (int col = 0; col < GLYPH_COLUMNS; col++)
        begin
            line = (int'(glyph) < GLYPH_COUNT_DEF) ?
                   font_mirror[int'(glyph) * GLYPH_COLUMNS + col] : 8'h00;
            for (int row = 0; row < GLYPH_ROWS; row++)
            begin
                color = line[row] ? req.fg_color : req.bg_color;
                cells.push_back(clip_cell(px + col * s, py + row * s, s, s, color,
                                          line[row] || opaque));
            end
        end
        // background column: eight dots at scale one, one tall bar above that
        if (opaque)
        begin
            if (s == 1)
            begin
                for (int row = 0; row < GLYPH_ROWS; row++)
                    cells.push_back(clip_cell(px + GLYPH_COLUMNS, py + row, 1, 1,
                                              req.bg_color, 1'b1));
            end
            else
            begin
                cells.push_back(clip_cell(px + GLYPH_COLUMNS * s, py, s, GLYPH_ROWS * s,
                                          req.bg_color, 1'b1));
            end
        end
        tail = cells.pop_back();
        tail.last = 1'b1;
        cells.push_back(tail);
        return cells;
    endfunction

    // Unused payload fields carry random noise
    function automatic gcr_in_t noise_req();
        logic [127:0] noise;
        noise = {$urandom(), $urandom(), $urandom(), $urandom()};
        return noise[$bits(gcr_in_t)-1:0];
    endfunction

    function automatic gcr_in_t load_req(input logic [10:0] idx, input logic [7:0] font_byte);
        gcr_in_t req;
        req = noise_req();
        req.cmd = CMD_LOAD;
        req.font_index = idx;
        req.font_byte = font_byte;
        return req;
    endfunction

    function automatic gcr_in_t draw_req(input logic [7:0] code, input int x, input int y,
                                         input logic [15:0] fg, input logic [15:0] bg,
                                         input logic [7:0] s);
        gcr_in_t req;
        req = noise_req();
        req.cmd = CMD_DRAW;
        req.char_code = code;
        req.pos_x = 16'(x);
        req.pos_y = 16'(y);
        req.fg_color = fg;
        req.bg_color = bg;
        req.glyph_scale = s;
        return req;
    endfunction

    function automatic void add_row(input gcr_in_t req, input bit typed, input int n,
                                    input logic [15:0] color);
        stim_row_t r;
        r.req = req;
        r.typed = typed;
        r.n = n;
        r.typed_cell = '0;
        r.typed_cell.fill_color = color;
        directed_rows.push_back(r);
    endfunction

    function automatic int random_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return int'($urandom_range(0, 16)) - 8;
        if (r < 70)
            return int'($urandom_range(0, 1100)) - 60;
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    // Offer one request after a random gap, then queue its expected cells
    task automatic issue_request(input gcr_in_t req, input bit typed, input int typed_n,
                                 input gcr_out_t typed_cell);
        int gap;
        cell_list_t cells;
        gcr_out_t tail;
        gap = idle_cycles();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid = 1'b1;
        in_data = req;
        do @(posedge clk); while (!in_ready);
        cells = predict_request(req);
        if (typed)
        begin
            cells = {};
            for (int i = 0; i < typed_n; i++)
                cells.push_back(typed_cell);
            if (typed_n > 0)
            begin
                tail = cells.pop_back();
                tail.last = 1'b1;
                cells.push_back(tail);
            end
        end
        foreach (cells[i])
            pending_cells.push_back(cells[i]);
        if (req.cmd == CMD_LOAD)
            loads_sent++;
        else
            draws_sent++;
    endtask

    // Drop valid, wait for every expected cell, then let the block settle
    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_cells.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Random request: a load (some out of range), or a draw of a fully loaded glyph
    task automatic issue_random_item();
        logic [10:0] idx;
        logic [7:0] code;
        logic [15:0] fg;
        logic [15:0] bg;
        int base;
        int s;
        int r;
        if ($urandom_range(0, 99) < 25)
        begin
            idx = ($urandom_range(0, 99) < 85) ? 11'($urandom_range(0, STORE_DEPTH - 1)) :
                                                 11'($urandom_range(STORE_DEPTH, 2047));
            issue_request(load_req(idx, 8'($urandom())), 1'b0, 0, '0);
            if (int'(idx) < STORE_DEPTH)
                phase_items++;
        end
        else
        begin
            if (ready_codes.size() == 0 || $urandom_range(0, 99) < 12)
            begin
                // fresh glyph: load any column not yet written
                code = 8'($urandom());
                base = int'(remap_code(code)) * GLYPH_COLUMNS;
                for (int c = 0; c < GLYPH_COLUMNS; c++)
                begin
                    if (!font_loaded[base + c])
                    begin
                        issue_request(load_req(11'(base + c), 8'($urandom())), 1'b0, 0, '0);
                        phase_items++;
                    end
                end
                ready_codes.push_back(code);
            end
            else
            begin
                code = ready_codes[$urandom_range(0, ready_codes.size() - 1)];
            end
            r = $urandom_range(0, 99);
            if (r < 5)
                s = 0;
            else if (r < 35)
                s = 1;
            else if (r < 80)
                s = $urandom_range(2, 4);
            else if (r < 95)
                s = $urandom_range(5, 16);
            else
                s = $urandom_range(17, 255);
            fg = 16'($urandom());
            bg = ($urandom_range(0, 99) < 40) ? fg : 16'($urandom());
            issue_request(draw_req(code, random_coord(), random_coord(), fg, bg, 8'(s)),
                          1'b0, 0, '0);
            phase_items++;
        end
    endtask

    // Main sequence: reset, directed table, then phases of window settings
    initial
    begin : stimulus
        logic [10:0] phase_w [N_PHASES];
        logic [10:0] phase_h [N_PHASES];
        int budget [N_PHASES];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_WINDOW_WIDTH;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        no_idle = 1'b0;
        win_w = WIN_WIDTH_RST;
        win_h = WIN_HEIGHT_RST;
        phase_items = 0;
        loads_sent = 0;
        draws_sent = 0;
        cells_checked = 0;
        settings_written = 0;
        mismatches = 0;
        phase_w = '{WIN_WIDTH_RST, 11'd1024, 11'd1, 11'd2047, 11'd0, 11'd320,
                    11'($urandom_range(1, 1024)), 11'($urandom_range(1, 1024))};
        phase_h = '{WIN_HEIGHT_RST, 11'd1024, 11'd1, 11'd1025, 11'd240, 11'd0,
                    11'($urandom_range(1, 1024)), 11'($urandom_range(1, 1024))};
        budget = '{60, 70, 40, 60, 30, 30, 80, 80};

        // glyph 0, glyph 177 (code 176), blank glyph 32, top store entry
        add_row(load_req(11'd0, 8'hFF), 1'b1, 0, 16'h0);
        add_row(load_req(11'd1, 8'h00), 1'b1, 0, 16'h0);
        add_row(load_req(11'd2, 8'h81), 1'b1, 0, 16'h0);
        add_row(load_req(11'd3, 8'h55), 1'b1, 0, 16'h0);
        add_row(load_req(11'd4, 8'hAA), 1'b1, 0, 16'h0);
        add_row(load_req(11'd885, 8'h01), 1'b1, 0, 16'h0);
        add_row(load_req(11'd886, 8'h80), 1'b1, 0, 16'h0);
        add_row(load_req(11'd887, 8'h3C), 1'b1, 0, 16'h0);
        add_row(load_req(11'd888, 8'hFF), 1'b1, 0, 16'h0);
        add_row(load_req(11'd889, 8'h7E), 1'b1, 0, 16'h0);
        add_row(load_req(11'd160, 8'h00), 1'b1, 0, 16'h0);
        add_row(load_req(11'd161, 8'h00), 1'b1, 0, 16'h0);
        add_row(load_req(11'd162, 8'h00), 1'b1, 0, 16'h0);
        add_row(load_req(11'd163, 8'h00), 1'b1, 0, 16'h0);
        add_row(load_req(11'd164, 8'h00), 1'b1, 0, 16'h0);
        add_row(load_req(11'd1279, 8'h5A), 1'b1, 0, 16'h0);
        // loads past the store end are dropped
        add_row(load_req(11'd1280, 8'hFF), 1'b1, 0, 16'h0);
        add_row(load_req(11'd2047, 8'hFF), 1'b1, 0, 16'h0);
        // code 255 wraps to glyph 0
        add_row(draw_req(8'd255, 0, 0, 16'hF800, 16'h001F, 8'd1), 1'b0, 0, 16'h0);
        // zero scale draws nothing
        add_row(draw_req(8'd0, 10, 10, 16'hFFFF, 16'h0000, 8'd0), 1'b1, 0, 16'h0);
        // transparent blank glyph fully off the window, both corners
        add_row(draw_req(8'd32, -32768, -32768, 16'h1234, 16'h1234, 8'd255),
                1'b1, GLYPH_COLUMNS * GLYPH_ROWS, 16'h1234);
        add_row(draw_req(8'd32, 32767, 32767, 16'hFFFF, 16'hFFFF, 8'd255),
                1'b1, GLYPH_COLUMNS * GLYPH_ROWS, 16'hFFFF);
        add_row(draw_req(8'd176, 300, 200, 16'h07E0, 16'h0000, 8'd3), 1'b0, 0, 16'h0);
        add_row(draw_req(8'd0, 0, 0, 16'hFFFF, 16'h0000, 8'd255), 1'b0, 0, 16'h0);
        add_row(draw_req(8'd176, -3, -5, 16'h8410, 16'h8410, 8'd2), 1'b0, 0, 16'h0);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int p = 0; p < N_PHASES; p++)
        begin
            // window registers change only while the block is idle
            if (p > 0)
            begin
                wait_idle();
                @(negedge clk);
                cfg_we = 1'b1;
                cfg_index = REG_WINDOW_WIDTH;
                cfg_data = phase_w[p];
                @(negedge clk);
                cfg_index = REG_WINDOW_HEIGHT;
                cfg_data = phase_h[p];
                @(negedge clk);
                cfg_we = 1'b0;
                win_w = phase_w[p];
                win_h = phase_h[p];
                settings_written++;
            end
            no_idle = (p == 1 || p == 3);
            if (p == 3)
                -> hold_start;
            if (p == 0)
            begin
                foreach (directed_rows[i])
                    issue_request(directed_rows[i].req, directed_rows[i].typed,
                                  directed_rows[i].n, directed_rows[i].typed_cell);
                ready_codes = '{8'd0, 8'd255, 8'd176, 8'd32};
            end
            phase_items = 0;
            while (phase_items < budget[p])
                issue_random_item();
        end
        wait_idle();

        $display("covered %0d loads and %0d draws, %0d cells checked, %0d window settings",
                 loads_sent, draws_sent, cells_checked, settings_written + 1);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Result side: random stall before each cell
    initial
    begin : receiver
        int stall;
        rx_ready = 1'b0;
        forever
        begin
            stall = idle_cycles();
            if (stall > 0)
            begin
                @(negedge clk);
                rx_ready = 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            rx_ready = 1'b1;
            do @(posedge clk); while (!(rst_n && out_valid && out_ready));
        end
    end

    // Long receiver hold-off so the block backs up and stalls its input
    initial
    begin : receiver_hold_off
        rx_hold = 1'b0;
        @(hold_start);
        @(negedge clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        rx_hold = 1'b0;
    end

    // Compare each accepted cell with the oldest expected one
    always @(posedge clk)
    begin : cell_monitor
        gcr_out_t exp_cell;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_cells.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected cell: x=%0d y=%0d w=%0d h=%0d color=%h we=%b last=%b",
                             out_data.rect_x, out_data.rect_y, out_data.rect_w,
                             out_data.rect_h, out_data.fill_color, out_data.write_enable,
                             out_data.last);
            end
            else
            begin
                exp_cell = pending_cells.pop_front();
                cells_checked++;
                if (out_data.rect_x !== exp_cell.rect_x ||
                    out_data.rect_y !== exp_cell.rect_y ||
                    out_data.rect_w !== exp_cell.rect_w ||
                    out_data.rect_h !== exp_cell.rect_h ||
                    out_data.fill_color !== exp_cell.fill_color ||
                    out_data.write_enable !== exp_cell.write_enable ||
                    out_data.last !== exp_cell.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("cell mismatch: exp x=%0d y=%0d w=%0d h=%0d c=%h we=%b l=%b",
                                 exp_cell.rect_x, exp_cell.rect_y, exp_cell.rect_w,
                                 exp_cell.rect_h, exp_cell.fill_color,
                                 exp_cell.write_enable, exp_cell.last);
                        $display("               got x=%0d y=%0d w=%0d h=%0d c=%h we=%b l=%b",
                                 out_data.rect_x, out_data.rect_y, out_data.rect_w,
                                 out_data.rect_h, out_data.fill_color,
                                 out_data.write_enable, out_data.last);
                    end
                end
            end
        end
    end

    // Watchdog, far beyond the slowest legal run
    initial
    begin : watchdog
        #12_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
